/* src/slcd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcd_pkg
// Shared types, constants and lookup functions for the segment LCD
// shadow RAM writer.
// ----------------------------------------------------------------------------
package slcd_pkg;

  localparam int DISPLAY_ENTRIES = 16;
  localparam int IDX_W = $clog2(DISPLAY_ENTRIES);
  localparam int ADDR_W = 5;
  localparam logic [ADDR_W:0] ENTRIES_LIM = (ADDR_W + 1)'(DISPLAY_ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DISPLAY_ENTRIES - 1);

  localparam int QUEUE_DEPTH = 2;
  localparam int QP_W = $clog2(QUEUE_DEPTH);
  localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [ADDR_W-1:0] BAR_LEFT_ADDR = 5'h07;
  localparam logic [ADDR_W-1:0] BAR_RIGHT_ADDR = 5'h06;
  localparam logic [ADDR_W-1:0] DIGIT_BASE_LEFT = 5'd2;
  localparam logic [ADDR_W-1:0] DIGIT_BASE_RIGHT = 5'd5;

  localparam logic [7:0] SEG_MINUS = 8'h04;
  localparam logic [7:0] SEG_BLANK = 8'h00;
  localparam logic [7:0] DIGIT_KEEP = 8'h01;
  localparam logic [7:0] BAR_LEFT_KEEP = 8'h71;
  localparam logic [7:0] BAR_RIGHT_KEEP = 8'hF0;
  localparam logic [2:0] BAR_MAX = 3'd4;

  localparam int DIV10_MUL = 205;
  localparam int DIV10_SHIFT = 11;

  typedef enum logic [2:0] {
    ACT_NUMBER = 3'd0,
    ACT_SYMBOL = 3'd1,
    ACT_BAR    = 3'd2,
    ACT_FILL   = 3'd3,
    ACT_QUERY  = 3'd4
  } act_t;

  typedef struct packed {
    act_t              op;
    logic              side;
    logic              neg;
    logic [9:0]        mag;
    logic [ADDR_W-1:0] addr;
    logic [2:0]        bitnum;
    logic              enable;
    logic [2:0]        level;
    logic [7:0]        fill;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } req_t;

  function automatic logic [7:0] seg_code(input logic [3:0] digit);
    logic [7:0] code;
    case (digit)
      4'd0: code = 8'b11111010;
      4'd1: code = 8'b00001010;
      4'd2: code = 8'b10111100;
      4'd3: code = 8'b10011110;
      4'd4: code = 8'b01001110;
      4'd5: code = 8'b11010110;
      4'd6: code = 8'hF6;
      4'd7: code = 8'h8A;
      4'd8: code = 8'hFE;
      4'd9: code = 8'hDE;
      default: code = SEG_BLANK;
    endcase
    return code;
  endfunction

  function automatic logic [7:0] bar_left_bits(input logic [2:0] level);
    logic [7:0] bits;
    case (level)
      3'd1: bits = 8'h80;
      3'd2: bits = 8'h88;
      3'd3: bits = 8'h8C;
      3'd4: bits = 8'h8E;
      default: bits = 8'h00;
    endcase
    return bits;
  endfunction

  function automatic logic [7:0] bar_right_bits(input logic [2:0] level);
    logic [7:0] bits;
    case (level)
      3'd1: bits = 8'h01;
      3'd2: bits = 8'h09;
      3'd3: bits = 8'h0D;
      3'd4: bits = 8'h0F;
      default: bits = 8'h00;
    endcase
    return bits;
  endfunction

endpackage

/* src/slcd_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcd_front
// Checks each accepted request, drops those out of range and builds the
// command descriptor that is pushed into the queue.
// ----------------------------------------------------------------------------
module slcd_front (
  input  logic                        accept,
  input  logic [2:0]                  in_action,
  input  logic                        in_side,
  input  logic signed [10:0]          in_number_value,
  input  logic [7:0]                  in_symbol_index,
  input  logic                        in_enable,
  input  logic [2:0]                  in_bar_level,
  input  logic [7:0]                  in_fill_value,
  output slcd_pkg::req_t              push
);

  logic              cmd_ok;
  logic signed [10:0] abs_w;
  logic [slcd_pkg::ADDR_W-1:0] sym_addr;

  assign sym_addr = in_symbol_index[7:3];
  assign abs_w = in_number_value[10] ? -in_number_value : in_number_value;

  always_comb begin
    case (in_action)
      slcd_pkg::ACT_NUMBER: begin
        cmd_ok = (in_number_value >= -11'sd99) && (in_number_value <= 11'sd999);
      end
      slcd_pkg::ACT_SYMBOL, slcd_pkg::ACT_QUERY: begin
        cmd_ok = {1'b0, sym_addr} < slcd_pkg::ENTRIES_LIM;
      end
      slcd_pkg::ACT_BAR: begin
        cmd_ok = in_bar_level <= slcd_pkg::BAR_MAX;
      end
      slcd_pkg::ACT_FILL: begin
        cmd_ok = 1'b1;
      end
      default: begin
        cmd_ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    push.valid      = accept && cmd_ok;
    push.cmd.op     = slcd_pkg::act_t'(in_action);
    push.cmd.side   = in_side;
    push.cmd.neg    = in_number_value[10];
    push.cmd.mag    = abs_w[9:0];
    push.cmd.addr   = sym_addr;
    push.cmd.bitnum = in_symbol_index[2:0];
    push.cmd.enable = in_enable;
    push.cmd.level  = in_bar_level;
    push.cmd.fill   = in_fill_value;
  end

endmodule

/* src/slcd_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcd_queue
// Short command queue between the front and the back, so that each side
// can stall on its own.
// ----------------------------------------------------------------------------
module slcd_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  slcd_pkg::req_t  push,
  input  logic            pop,
  output logic            full,
  output slcd_pkg::req_t  head
);

  slcd_pkg::cmd_t                 mem_r [slcd_pkg::QUEUE_DEPTH];
  logic [slcd_pkg::QP_W-1:0]      wr_ptr_r;
  logic [slcd_pkg::QP_W-1:0]      rd_ptr_r;
  logic [slcd_pkg::QC_W-1:0]      count_r;
  logic                           do_push;
  logic                           do_pop;

  assign full = count_r == slcd_pkg::QC_W'(slcd_pkg::QUEUE_DEPTH);
  assign do_push = push.valid && !full;
  assign do_pop = pop && (count_r != '0);
  assign head.valid = count_r != '0;
  assign head.cmd = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        mem_r[wr_ptr_r] <= push.cmd;
        wr_ptr_r        <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

/* src/slcd_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcd_back
// Executes queued commands on the display shadow RAM, one entry write
// or query reply per cycle once taken, and drives the result strobe.
// ----------------------------------------------------------------------------
module slcd_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  slcd_pkg::req_t              head,
  output logic                        pop,
  output logic                        out_valid,
  output logic                        out_kind,
  output logic [slcd_pkg::ADDR_W-1:0] out_address,
  output logic [7:0]                  out_data,
  output logic                        out_symbol_on,
  output logic                        out_last
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SINGLE,
    S_DIGIT,
    S_REST,
    S_FILL
  } state_t;

  state_t                        state_r, state_nxt;
  slcd_pkg::cmd_t                cmd_r, cmd_nxt;
  logic [1:0]                    pos_r, pos_nxt;
  logic [9:0]                    mag_r, mag_nxt;
  logic                          minus_r, minus_nxt;
  logic [slcd_pkg::IDX_W-1:0]    cnt_r, cnt_nxt;
  logic [7:0]                    shadow_r [slcd_pkg::DISPLAY_ENTRIES];

  logic                          out_valid_r, out_valid_nxt;
  logic                          out_kind_r, out_kind_nxt;
  logic [slcd_pkg::ADDR_W-1:0]   out_addr_r, out_addr_nxt;
  logic [7:0]                    out_data_r, out_data_nxt;
  logic                          out_sym_r, out_sym_nxt;
  logic                          out_last_r, out_last_nxt;

  logic                          we;
  logic [slcd_pkg::ADDR_W-1:0]   rd_addr;
  logic [7:0]                    sh_rd;
  logic [slcd_pkg::ADDR_W-1:0]   digit_addr;
  logic [17:0]                   prod;
  logic [6:0]                    quot;
  logic [3:0]                    digit;
  logic [7:0]                    bmask;

  assign digit_addr = (cmd_r.side ? slcd_pkg::DIGIT_BASE_RIGHT : slcd_pkg::DIGIT_BASE_LEFT)
                      - slcd_pkg::ADDR_W'(pos_r);
  assign prod  = 18'(mag_r) * 18'(slcd_pkg::DIV10_MUL);
  assign quot  = 7'(prod >> slcd_pkg::DIV10_SHIFT);
  assign digit = 4'(mag_r - (10'(quot) << 3) - (10'(quot) << 1));
  assign bmask = 8'b1 << cmd_r.bitnum;

  always_comb begin
    case (state_r)
      S_SINGLE: begin
        if (cmd_r.op == slcd_pkg::ACT_BAR) begin
          rd_addr = cmd_r.side ? slcd_pkg::BAR_RIGHT_ADDR : slcd_pkg::BAR_LEFT_ADDR;
        end else begin
          rd_addr = cmd_r.addr;
        end
      end
      S_DIGIT, S_REST: begin
        rd_addr = digit_addr;
      end
      default: begin
        rd_addr = slcd_pkg::ADDR_W'(cnt_r);
      end
    endcase
  end

  assign sh_rd = shadow_r[rd_addr[slcd_pkg::IDX_W-1:0]];

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    pos_nxt       = pos_r;
    mag_nxt       = mag_r;
    minus_nxt     = minus_r;
    cnt_nxt       = cnt_r;
    pop           = 1'b0;
    we            = 1'b0;
    out_valid_nxt = 1'b0;
    out_kind_nxt  = 1'b0;
    out_addr_nxt  = rd_addr;
    out_data_nxt  = sh_rd;
    out_sym_nxt   = 1'b0;
    out_last_nxt  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (head.valid) begin
          pop       = 1'b1;
          cmd_nxt   = head.cmd;
          pos_nxt   = 2'd0;
          mag_nxt   = head.cmd.mag;
          minus_nxt = head.cmd.neg;
          cnt_nxt   = '0;
          case (head.cmd.op)
            slcd_pkg::ACT_NUMBER: state_nxt = S_DIGIT;
            slcd_pkg::ACT_FILL:   state_nxt = S_FILL;
            default:              state_nxt = S_SINGLE;
          endcase
        end
      end
      S_SINGLE: begin
        out_valid_nxt = 1'b1;
        out_last_nxt  = 1'b1;
        state_nxt     = S_IDLE;
        case (cmd_r.op)
          slcd_pkg::ACT_SYMBOL: begin
            we           = 1'b1;
            out_data_nxt = (sh_rd & ~bmask) | (cmd_r.enable ? bmask : 8'h00);
          end
          slcd_pkg::ACT_BAR: begin
            we = 1'b1;
            if (cmd_r.side) begin
              out_data_nxt = (sh_rd & slcd_pkg::BAR_RIGHT_KEEP)
                             | slcd_pkg::bar_right_bits(cmd_r.level);
            end else begin
              out_data_nxt = (sh_rd & slcd_pkg::BAR_LEFT_KEEP)
                             | slcd_pkg::bar_left_bits(cmd_r.level);
            end
          end
          default: begin
            out_kind_nxt = 1'b1;
            out_sym_nxt  = sh_rd[cmd_r.bitnum];
          end
        endcase
      end
      S_DIGIT: begin
        we            = 1'b1;
        out_valid_nxt = 1'b1;
        out_data_nxt  = (sh_rd & slcd_pkg::DIGIT_KEEP) | slcd_pkg::seg_code(digit);
        mag_nxt       = 10'(quot);
        if (pos_r == 2'd2) begin
          out_last_nxt = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          pos_nxt = pos_r + 2'd1;
          if (quot == '0) begin
            state_nxt = S_REST;
          end
        end
      end
      S_REST: begin
        we            = 1'b1;
        out_valid_nxt = 1'b1;
        out_data_nxt  = (sh_rd & slcd_pkg::DIGIT_KEEP)
                        | (minus_r ? slcd_pkg::SEG_MINUS : slcd_pkg::SEG_BLANK);
        minus_nxt     = 1'b0;
        if (pos_r == 2'd2) begin
          out_last_nxt = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          pos_nxt = pos_r + 2'd1;
        end
      end
      S_FILL: begin
        we            = 1'b1;
        out_valid_nxt = 1'b1;
        out_data_nxt  = cmd_r.fill;
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == slcd_pkg::LAST_IDX) begin
          out_last_nxt = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < slcd_pkg::DISPLAY_ENTRIES; i++) begin
        shadow_r[i] <= 8'h00;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (we) begin
        shadow_r[rd_addr[slcd_pkg::IDX_W-1:0]] <= out_data_nxt;
      end
    end
    cmd_r      <= cmd_nxt;
    pos_r      <= pos_nxt;
    mag_r      <= mag_nxt;
    minus_r    <= minus_nxt;
    cnt_r      <= cnt_nxt;
    out_kind_r <= out_kind_nxt;
    out_addr_r <= out_addr_nxt;
    out_data_r <= out_data_nxt;
    out_sym_r  <= out_sym_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_kind      = out_kind_r;
  assign out_address   = out_addr_r;
  assign out_data      = out_data_r;
  assign out_symbol_on = out_sym_r;
  assign out_last      = out_last_r;

  a_query_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_kind_r |-> out_last_r)
    else $error("query reply is not the final result");

  a_write_lands: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_kind_r |->
      shadow_r[out_addr_r[slcd_pkg::IDX_W-1:0]] == out_data_r)
    else $error("emitted write does not match the shadow entry");

  a_pop_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE && head.valid |=> state_r != S_IDLE)
    else $error("queued command was not taken");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIGIT || state_r == S_REST |-> pos_r <= 2'd2)
    else $error("digit position out of range");

endmodule

/* src/segment_lcd_shadow_ram_writer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_lcd_shadow_ram_writer
// Turns display requests into byte writes against a shadow copy of a
// segment LCD's display RAM, with read-modify-write of each entry.
// ----------------------------------------------------------------------------
// A request is taken at a clock edge where start is high and busy is low.
// Requests that are out of range are taken and produce no result.
// Each result appears for one cycle with out_valid high; out_last marks the
// final result of a request. The receiver cannot hold results off.
// A taken request is written into the queue, taken from it by the execution
// unit while idle, executed, and its first result registered on the outputs.
// After taking a request the execution unit produces one result per cycle:
// one for symbol, bar and query requests, three for a number (one per digit
// position, dividing by ten each step), and sixteen for a fill (one per
// display entry). It takes the next request only after the last result.
// A two-entry queue in front of the execution unit holds requests while it
// works; busy is high while the queue is full.
// Reset clears the shadow RAM, the queue and the result strobe.
// ----------------------------------------------------------------------------
module segment_lcd_shadow_ram_writer (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [2:0]                  in_action,
  input  logic                        in_side,
  input  logic signed [10:0]          in_number_value,
  input  logic [7:0]                  in_symbol_index,
  input  logic                        in_enable,
  input  logic [2:0]                  in_bar_level,
  input  logic [7:0]                  in_fill_value,
  output logic                        out_valid,
  output logic                        out_kind,
  output logic [slcd_pkg::ADDR_W-1:0] out_address,
  output logic [7:0]                  out_data,
  output logic                        out_symbol_on,
  output logic                        out_last
);

  logic           accept;
  logic           q_full;
  logic           pop;
  slcd_pkg::req_t push;
  slcd_pkg::req_t head;

  assign busy   = q_full;
  assign accept = start && !q_full;

  slcd_front u_front (
    .accept          (accept),
    .in_action       (in_action),
    .in_side         (in_side),
    .in_number_value (in_number_value),
    .in_symbol_index (in_symbol_index),
    .in_enable       (in_enable),
    .in_bar_level    (in_bar_level),
    .in_fill_value   (in_fill_value),
    .push            (push)
  );

  slcd_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .full  (q_full),
    .head  (head)
  );

  slcd_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head          (head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_kind      (out_kind),
    .out_address   (out_address),
    .out_data      (out_data),
    .out_symbol_on (out_symbol_on),
    .out_last      (out_last)
  );

endmodule
